/* src/amm_pkg.sv */
// ----------------------------------------------------------------------------
// amm_pkg: shared types and constants of the audio matrix mixer
// Field widths, request and result codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package amm_pkg;

  localparam int NUM_IN_DEF     = 8;
  localparam int NUM_OUT_DEF    = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_BITS      = 24;
  localparam int GAIN_FRAC_BITS = 20;
  localparam int CH_BITS        = 6;
  localparam int REQ_BITS       = 2;
  localparam int CFG_W          = 4;
  localparam int CFG_ADDR_W     = 1;
  localparam int S_TDATA_W      = 64;
  localparam int M_TDATA_W      = 56;

  localparam logic signed [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;

  localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_IN  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_OUT = 1'b1;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_t;

  typedef enum logic {
    KIND_GAIN = 1'b0,
    KIND_MIX  = 1'b1
  } kind_t;

  typedef struct packed {
    logic               clr;
    logic               wr_gain;
    logic               wr_smp;
    logic               rd_gain;
    logic               mac_rd;
    logic               mac_first;
    logic               ld_gain;
    logic               ld_mix;
    logic               mix_last;
    logic [CH_BITS-1:0] o;
    logic [CH_BITS-1:0] i;
  } cmd_t;

  typedef struct packed {
    logic in_rng;
    logic smp_rng;
    logic smp_end;
    logic busy;
    logic out_free;
  } sts_t;

endpackage

/* src/audio_matrix_mixer_core.sv */
// ----------------------------------------------------------------------------
// audio_matrix_mixer_core: multichannel audio gain matrix
// Keeps an output-by-input table of Q4.20 gains and mixes each frame of
// input samples into rounded, saturated output samples.
// ----------------------------------------------------------------------------
// After reset the block clears the gain table to identity and the frame store
// to zero, one table entry per cycle, and takes no beat until the whole table
// is cleared. A readback reads the gain memory and then waits until the
// result register is free. The sample for the last active input closes the
// frame and starts a single multiply-accumulate unit that reads one gain and
// one stored sample per cycle while it steps over the inputs of an output,
// and waits after each output until the pipeline drains and the result
// register is free. The pace is set by the one read port of the gain memory
// and the three-stage read, multiply and accumulate pipeline. Each result
// waits in an output register until taken.
module audio_matrix_mixer_core #(
  parameter int NUM_IN  = amm_pkg::NUM_IN_DEF,
  parameter int NUM_OUT = amm_pkg::NUM_OUT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // out_channel, in_channel, gain, sample, zero pad
  input  logic [amm_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type
  input  logic [amm_pkg::REQ_BITS-1:0]    s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_index, gain_value, mixed_sample, zero pad
  output logic [amm_pkg::M_TDATA_W-1:0]   m_tdata,
  // result_kind
  output logic                            m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [amm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [amm_pkg::CFG_W-1:0]       cfg_wdata
);
  import amm_pkg::*;

  localparam int I_W = (NUM_IN > 1) ? $clog2(NUM_IN) : 1;
  localparam int O_W = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;

  logic [CFG_W-1:0] active_inputs;
  logic [CFG_W-1:0] active_outputs;
  logic [I_W-1:0]   ni_last;
  logic [O_W-1:0]   no_last;
  cmd_t             cmd;
  sts_t             sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs  <= CFG_W'(8);
      active_outputs <= CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ACTIVE_IN:  active_inputs  <= cfg_wdata;
        CFG_ACTIVE_OUT: active_outputs <= cfg_wdata;
        default:        active_inputs  <= active_inputs;
      endcase
    end
  end

  always_comb begin
    if (active_inputs == '0) begin
      ni_last = '0;
    end else if (32'(active_inputs) > 32'(NUM_IN)) begin
      ni_last = I_W'(NUM_IN - 1);
    end else begin
      ni_last = I_W'(active_inputs - 1'b1);
    end
    if (active_outputs == '0) begin
      no_last = '0;
    end else if (32'(active_outputs) > 32'(NUM_OUT)) begin
      no_last = O_W'(NUM_OUT - 1);
    end else begin
      no_last = O_W'(active_outputs - 1'b1);
    end
  end

  amm_ctrl #(
    .NUM_IN  (NUM_IN),
    .NUM_OUT (NUM_OUT),
    .I_W     (I_W),
    .O_W     (O_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .ni_last  (ni_last),
    .no_last  (no_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  amm_datapath #(
    .NUM_IN  (NUM_IN),
    .NUM_OUT (NUM_OUT),
    .I_W     (I_W),
    .O_W     (O_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .ni_last  (ni_last),
    .no_last  (no_last),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/amm_ctrl.sv */
// ----------------------------------------------------------------------------
// amm_ctrl: sequencer of the audio matrix mixer
// Runs the gain table clearing pass, decodes requests, and steps the
// multiply-accumulate unit over outputs and inputs of a frame.
// ----------------------------------------------------------------------------
module amm_ctrl #(
  parameter int NUM_IN  = amm_pkg::NUM_IN_DEF,
  parameter int NUM_OUT = amm_pkg::NUM_OUT_DEF,
  parameter int I_W     = (NUM_IN > 1) ? $clog2(NUM_IN) : 1,
  parameter int O_W     = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [amm_pkg::REQ_BITS-1:0]  s_tuser,
  input  logic [I_W-1:0]                ni_last,
  input  logic [O_W-1:0]                no_last,
  input  amm_pkg::sts_t                 sts,
  output amm_pkg::cmd_t                 cmd
);
  import amm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDGAIN,
    S_MAC,
    S_EMIT
  } state_t;

  localparam logic [I_W-1:0] I_LAST = I_W'(NUM_IN - 1);
  localparam logic [O_W-1:0] O_LAST = O_W'(NUM_OUT - 1);

  state_t         state;
  logic [I_W-1:0] i_cnt;
  logic [O_W-1:0] o_cnt;
  logic           accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd           = '0;
    cmd.o         = CH_BITS'(o_cnt);
    cmd.i         = CH_BITS'(i_cnt);
    cmd.mac_first = (i_cnt == '0);
    cmd.mix_last  = (o_cnt == no_last);
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          case (req_t'(s_tuser))
            REQ_WRITE:  cmd.wr_gain = sts.in_rng;
            REQ_READ:   cmd.rd_gain = 1'b1;
            REQ_SAMPLE: cmd.wr_smp  = sts.smp_rng;
            default:    cmd.wr_smp  = 1'b0;
          endcase
        end
      end
      S_RDGAIN: begin
        cmd.ld_gain = sts.out_free;
      end
      S_MAC: begin
        cmd.mac_rd = 1'b1;
      end
      S_EMIT: begin
        cmd.ld_mix = !sts.busy && sts.out_free;
      end
      default: begin
        cmd.clr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      i_cnt <= '0;
      o_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (i_cnt == I_LAST) begin
            i_cnt <= '0;
            if (o_cnt == O_LAST) begin
              o_cnt <= '0;
              state <= S_IDLE;
            end else begin
              o_cnt <= o_cnt + 1'b1;
            end
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req_t'(s_tuser))
              REQ_READ: state <= S_RDGAIN;
              REQ_SAMPLE: begin
                if (sts.smp_rng && sts.smp_end) begin
                  i_cnt <= '0;
                  o_cnt <= '0;
                  state <= S_MAC;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RDGAIN: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        S_MAC: begin
          if (i_cnt == ni_last) begin
            i_cnt <= '0;
            state <= S_EMIT;
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (!sts.busy && sts.out_free) begin
            if (o_cnt == no_last) begin
              o_cnt <= '0;
              state <= S_IDLE;
            end else begin
              o_cnt <= o_cnt + 1'b1;
              state <= S_MAC;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

/* src/amm_datapath.sv */
// ----------------------------------------------------------------------------
// amm_datapath: storage and arithmetic of the audio matrix mixer
// Holds the gain table and frame store memories, the pipelined
// multiply-accumulate unit, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module amm_datapath #(
  parameter int NUM_IN  = amm_pkg::NUM_IN_DEF,
  parameter int NUM_OUT = amm_pkg::NUM_OUT_DEF,
  parameter int I_W     = (NUM_IN > 1) ? $clog2(NUM_IN) : 1,
  parameter int O_W     = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [amm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [I_W-1:0]                 ni_last,
  input  logic [O_W-1:0]                 no_last,
  input  amm_pkg::cmd_t                  cmd,
  output amm_pkg::sts_t                  sts,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [amm_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import amm_pkg::*;

  localparam int DEPTH = NUM_OUT * NUM_IN;
  localparam int GA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = GAIN_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + I_W + 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam int PAD_W = M_TDATA_W - CH_BITS - GAIN_BITS - SAMPLE_BITS;

  logic signed [GAIN_BITS-1:0]   gmem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] fmem [NUM_IN];

  logic [CH_BITS-1:0]            oc;
  logic [CH_BITS-1:0]            ic;
  logic signed [GAIN_BITS-1:0]   gain_in;
  logic signed [SAMPLE_BITS-1:0] smp_in;
  logic [GA_W-1:0]               in_addr;
  logic [GA_W-1:0]               mac_addr;
  logic [GA_W-1:0]               rd_addr;
  logic [GA_W-1:0]               wr_addr;
  logic signed [GAIN_BITS-1:0]   wr_data;
  logic                          wr_en;
  logic                          rd_en;

  logic signed [GAIN_BITS-1:0]   gain_q;
  logic signed [SAMPLE_BITS-1:0] frame_q;
  logic                          rng_q;
  logic                          rd_vld;
  logic                          rd_first;
  logic signed [PROD_W-1:0]      prod;
  logic                          p_vld;
  logic                          p_first;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       shf;
  logic signed [SAMPLE_BITS-1:0] sat;

  logic                          r_kind;
  logic [CH_BITS-1:0]            r_idx;
  logic signed [GAIN_BITS-1:0]   r_gain;
  logic signed [SAMPLE_BITS-1:0] r_mix;
  logic                          r_last;

  assign oc      = s_tdata[CH_BITS-1:0];
  assign ic      = s_tdata[2*CH_BITS-1:CH_BITS];
  assign gain_in = s_tdata[2*CH_BITS+GAIN_BITS-1:2*CH_BITS];
  assign smp_in  = s_tdata[2*CH_BITS+GAIN_BITS+SAMPLE_BITS-1:2*CH_BITS+GAIN_BITS];

  assign in_addr  = GA_W'(oc[O_W-1:0]) * GA_W'(NUM_IN) + GA_W'(ic[I_W-1:0]);
  assign mac_addr = GA_W'(cmd.o[O_W-1:0]) * GA_W'(NUM_IN) + GA_W'(cmd.i[I_W-1:0]);

  assign sts.in_rng   = ({1'b0, oc} <= (CH_BITS+1)'(no_last)) &&
                        ({1'b0, ic} <= (CH_BITS+1)'(ni_last));
  assign sts.smp_rng  = ({1'b0, ic} <= (CH_BITS+1)'(ni_last));
  assign sts.smp_end  = ({1'b0, ic} == (CH_BITS+1)'(ni_last));
  assign sts.busy     = rd_vld || p_vld;
  assign sts.out_free = !m_tvalid || m_tready;

  assign wr_en   = cmd.clr || cmd.wr_gain;
  assign wr_addr = cmd.clr ? mac_addr : in_addr;
  assign wr_data = cmd.clr ? ((cmd.o == cmd.i) ? GAIN_ONE : '0) : gain_in;
  assign rd_en   = cmd.rd_gain || cmd.mac_rd;
  assign rd_addr = cmd.rd_gain ? in_addr : mac_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      gain_q <= gmem[rd_addr];
    end
    if (cmd.rd_gain) begin
      rng_q <= sts.in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && (cmd.o == '0)) begin
      fmem[cmd.i[I_W-1:0]] <= '0;
    end else if (cmd.wr_smp) begin
      fmem[ic[I_W-1:0]] <= smp_in;
    end
    if (cmd.mac_rd) begin
      frame_q <= fmem[cmd.i[I_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      p_vld  <= 1'b0;
    end else begin
      rd_vld <= cmd.mac_rd;
      p_vld  <= rd_vld;
    end
    rd_first <= cmd.mac_first;
    p_first  <= rd_first;
    prod     <= gain_q * frame_q;
    if (p_vld) begin
      acc <= p_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  assign rnd = acc + RND_HALF;
  assign shf = rnd >>> GAIN_FRAC_BITS;

  always_comb begin
    if (shf > SMAX) begin
      sat = SMAX[SAMPLE_BITS-1:0];
    end else if (shf < SMIN) begin
      sat = SMIN[SAMPLE_BITS-1:0];
    end else begin
      sat = shf[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.ld_gain || cmd.ld_mix) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.ld_gain) begin
      r_kind <= KIND_GAIN;
      r_idx  <= '0;
      r_gain <= rng_q ? gain_q : '0;
      r_mix  <= '0;
      r_last <= 1'b1;
    end else if (cmd.ld_mix) begin
      r_kind <= KIND_MIX;
      r_idx  <= cmd.o;
      r_gain <= '0;
      r_mix  <= sat;
      r_last <= cmd.mix_last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, r_mix, r_gain, r_idx};
  assign m_tuser = r_kind;
  assign m_tlast = r_last;

endmodule

/* src/amm_checker.sv */
// ----------------------------------------------------------------------------
// amm_checker: port-level checks of the audio matrix mixer
// Watches the stream ports for the block's sequencing rules.
// ----------------------------------------------------------------------------
module amm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [amm_pkg::REQ_BITS-1:0]    s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [amm_pkg::M_TDATA_W-1:0]   m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  import amm_pkg::*;

  // The clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !s_tready)
    else $error("input open during clearing pass");

  // A readback occupies the block on the following cycle.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_READ) |=> !s_tready)
    else $error("input open right after a readback beat");

  // A readback is always the final result of its beat.
  a_gain_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_GAIN) |-> m_tlast)
    else $error("readback without tlast");

  // While a frame still has outputs to deliver, no new beat is taken.
  a_frame_closed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_MIX) && !m_tlast |-> !s_tready)
    else $error("input open in the middle of a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind audio_matrix_mixer_core amm_checker u_amm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
